FILE: sv/arct_pkg.sv
// shared types, codes and defaults of the address range coalescing table
package arct_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned AddrBitsDefault   = 48;

  // fixed field widths of the request and result items
  localparam int unsigned IndexBits  = 4;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned StatusBits = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT,
    S_READ,
    S_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic compact;
    logic rewind;
    logic read_issue;
    logic commit;
  } arct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_read;
    logic scan_done;
    logic merge_many;
    logic out_free;
  } arct_sts_t;

endpackage

FILE: sv/arct_ram.sv
// generic single write port, single read port ram with registered read
module arct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/arct_ctrl.sv
// sequencing state machine of the address range coalescing table
module arct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  arct_pkg::arct_sts_t sts_i,
  output arct_pkg::arct_cmd_t cmd_o
);
  import arct_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = s_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          state_d = (op_e'(sts_i.op_read) == OP_READ) ? S_READ : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.merge_many ? S_COMPACT : S_FINISH;
        end
      end
      S_COMPACT: begin
        if (sts_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_READ:   state_d = S_FINISH;
      S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = accept;
      end
      S_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.rewind = sts_i.scan_done && sts_i.merge_many;
      end
      S_COMPACT: cmd_o.compact    = 1'b1;
      S_READ:    cmd_o.read_issue = 1'b1;
      S_FINISH:  cmd_o.commit     = sts_i.out_free;
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/arct_dp.sv
// table storage, overlap test, union accumulator and result register
module arct_dp #(
  parameter int unsigned TableDepth = arct_pkg::TableDepthDefault,
  parameter int unsigned AddrBits   = arct_pkg::AddrBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arct_pkg::arct_cmd_t           cmd_i,
  output arct_pkg::arct_sts_t           sts_o,
  input  logic                          in_op_i,
  input  logic [AddrBits-1:0]           in_start_i,
  input  logic [AddrBits-1:0]           in_length_i,
  input  logic [arct_pkg::IndexBits-1:0] in_index_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [arct_pkg::CountBits-1:0] out_count_o,
  output arct_pkg::status_e             out_status_o,
  output logic [AddrBits-1:0]           out_start_o,
  output logic [AddrBits:0]             out_length_o
);
  import arct_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned CntW  = $clog2(TableDepth + 1);
  localparam int unsigned LenW  = AddrBits + 1;
  localparam int unsigned EndW  = AddrBits + 2;
  localparam int unsigned WordW = AddrBits + LenW;
  localparam int unsigned CmpW  = CntW + IndexBits;

  // request registers
  op_e                  op_q;
  logic [AddrBits-1:0]  ns_q;
  logic [AddrBits-1:0]  nl_q;
  logic [LenW-1:0]      be_q;
  logic [IndexBits-1:0] idx_q;

  // table control
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] wptr_q, wptr_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic [1:0]      hits_q, hits_d;
  logic [IdxW-1:0] first_q, first_d;

  // union accumulator, kept as low start and high end
  logic [AddrBits-1:0] lo_q, lo_d;
  logic [LenW-1:0]     hi_q, hi_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [CntW-1:0]      res_count_q, res_count_d;
  status_e              res_status_q, res_status_d;
  logic [AddrBits-1:0]  res_start_q, res_start_d;
  logic [LenW-1:0]      res_len_q, res_len_d;

  // ram ports
  logic             wr_en, rd_en;
  logic [IdxW-1:0]  wr_addr, rd_addr;
  logic [WordW-1:0] wr_data, rd_data;

  logic [AddrBits-1:0] r_start;
  logic [LenW-1:0]     r_len;
  logic [EndW-1:0]     r_end;
  logic                hit;
  logic                more_to_read;
  logic                idx_ok;
  logic                table_full;
  logic [LenW-1:0]     union_len;

  assign r_start = rd_data[AddrBits-1:0];
  assign r_len   = rd_data[WordW-1:AddrBits];
  assign r_end   = EndW'(r_start) + EndW'(r_len);

  // half-open overlap, touching ranges do not count
  assign hit = ((r_start <= ns_q) && (EndW'(ns_q) < r_end)) ||
               ((ns_q <= r_start) && (LenW'(r_start) < be_q));

  assign more_to_read = (ptr_q < count_q);
  assign idx_ok       = (CmpW'(idx_q) < CmpW'(count_q));
  assign table_full   = (count_q == CntW'(TableDepth));
  assign union_len    = hi_q - LenW'(lo_q);

  assign sts_o.op_read    = in_op_i;
  assign sts_o.scan_done  = !more_to_read && !pv_q;
  assign sts_o.merge_many = hits_q[1];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    wptr_d       = wptr_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    hits_d       = hits_q;
    first_d      = first_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_len_d    = res_len_q;
    wr_en        = 1'b0;
    wr_addr      = count_q[IdxW-1:0];
    wr_data      = {LenW'(nl_q), ns_q};
    rd_en        = 1'b0;
    rd_addr      = ptr_q[IdxW-1:0];

    if (cmd_i.load) begin
      ptr_d  = '0;
      wptr_d = '0;
      hits_d = '0;
      lo_d   = in_start_i;
      hi_d   = LenW'(in_start_i) + LenW'(in_length_i);
    end

    // walk the valid entries, one ram read per cycle, data in the cycle after the read
    if (cmd_i.scan || cmd_i.compact) begin
      if (more_to_read) begin
        rd_en  = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        pv_d   = 1'b1;
        pidx_d = ptr_q[IdxW-1:0];
      end
    end

    if (cmd_i.scan && pv_q && hit) begin
      if (hits_q == 2'd0) begin
        first_d = pidx_q;
      end
      if (!hits_q[1]) begin
        hits_d = hits_q + 1'b1;
      end
      if (r_start < lo_q) begin
        lo_d = r_start;
      end
      if (r_end > EndW'(hi_q)) begin
        hi_d = LenW'(r_end);
      end
    end

    // keep entries that miss, packed to the front
    if (cmd_i.compact && pv_q && !hit) begin
      wr_en   = 1'b1;
      wr_addr = wptr_q[IdxW-1:0];
      wr_data = rd_data;
      wptr_d  = wptr_q + 1'b1;
    end

    if (cmd_i.rewind) begin
      ptr_d  = '0;
      wptr_d = '0;
      pv_d   = 1'b0;
    end

    if (cmd_i.read_issue) begin
      rd_en   = 1'b1;
      rd_addr = IdxW'(idx_q);
    end

    if (cmd_i.commit) begin
      out_valid_d  = 1'b1;
      res_status_d = STATUS_OK;
      res_start_d  = '0;
      res_len_d    = '0;
      if (op_q == OP_READ) begin
        if (idx_ok) begin
          res_start_d = r_start;
          res_len_d   = r_len;
        end else begin
          res_status_d = STATUS_BAD_INDEX;
        end
      end else if (hits_q == 2'd0) begin
        if (table_full) begin
          res_status_d = STATUS_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end else if (hits_q == 2'd1) begin
        wr_en   = 1'b1;
        wr_addr = first_q;
        wr_data = {union_len, lo_q};
      end else begin
        wr_en   = 1'b1;
        wr_addr = wptr_q[IdxW-1:0];
        wr_data = {union_len, lo_q};
        count_d = wptr_q + 1'b1;
      end
      res_count_d = (op_q == OP_READ) ? count_q : count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      wptr_q      <= '0;
      pv_q        <= 1'b0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      wptr_q      <= wptr_d;
      pv_q        <= pv_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(in_op_i);
      ns_q  <= in_start_i;
      nl_q  <= in_length_i;
      be_q  <= LenW'(in_start_i) + LenW'(in_length_i);
      idx_q <= in_index_i;
    end
    pidx_q       <= pidx_d;
    first_q      <= first_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_len_q    <= res_len_d;
  end

  arct_ram #(
    .Width (WordW),
    .Depth (TableDepth)
  ) u_arct_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o  = out_valid_q;
  assign out_count_o  = CountBits'(res_count_q);
  assign out_status_o = res_status_q;
  assign out_start_o  = res_start_q;
  assign out_length_o = res_len_q;

endmodule

FILE: sv/address_range_coalescing_table.sv
// top level of the address range coalescing table
//
// request channel (s_axis): tuser carries the op (0 insert a range, 1 read an
// entry); tdata carries start address, length and read index. result channel
// (m_axis): tuser carries the status (0 ok, 1 table full and insert dropped,
// 2 read index invalid); tdata carries the entry count after the request and,
// for a read, the start and length of the entry (zero otherwise).
// one request is worked on at a time; s_axis_tready is high while idle.
// a read issues one ram read at the index and registers the result. an insert
// walks the n valid entries through the table ram, one read a cycle, to count
// overlaps and grow the union; when two or more entries merge, a second walk
// packs the kept entries down. the result waits in an output register, so a new
// request can be accepted while the receiver stalls; the next result then waits
// for that register. reset empties the table (entry count zero) and drops any
// pending result; the table ram itself is not cleared, entries past the count
// are never returned.
module address_range_coalescing_table #(
  parameter int unsigned TableDepth = arct_pkg::TableDepthDefault,
  parameter int unsigned AddrBits   = arct_pkg::AddrBitsDefault,
  localparam int unsigned InBits    = 2 * AddrBits + arct_pkg::IndexBits,
  localparam int unsigned InW       = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits   = arct_pkg::CountBits + 2 * AddrBits + 1,
  localparam int unsigned OutW      = ((OutBits + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_address, length, read_index, zero pad
  input  logic [InW-1:0]                  s_axis_tdata,
  // op
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // entry_count, entry_start, entry_length, zero pad
  output logic [OutW-1:0]                 m_axis_tdata,
  // status
  output logic [arct_pkg::StatusBits-1:0] m_axis_tuser
);
  import arct_pkg::*;

  arct_cmd_t cmd;
  arct_sts_t sts;

  logic [CountBits-1:0] res_count;
  status_e              res_status;
  logic [AddrBits-1:0]  res_start;
  logic [AddrBits:0]    res_length;

  // sequencing
  arct_ctrl u_arct_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // storage, overlap test and result register
  arct_dp #(
    .TableDepth (TableDepth),
    .AddrBits   (AddrBits)
  ) u_arct_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tuser),
    .in_start_i   (s_axis_tdata[AddrBits-1:0]),
    .in_length_i  (s_axis_tdata[2*AddrBits-1:AddrBits]),
    .in_index_i   (s_axis_tdata[InBits-1:2*AddrBits]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_count_o  (res_count),
    .out_status_o (res_status),
    .out_start_o  (res_start),
    .out_length_o (res_length)
  );

  // pack result fields from the lowest bit up, pad bits zero
  assign m_axis_tdata = OutW'({res_length, res_start, res_count});
  assign m_axis_tuser = res_status;

endmodule

FILE: sv/arct_checker.sv
// port level checks of the address range coalescing table, bound to the top level
module arct_checker #(
  parameter int unsigned TableDepth = arct_pkg::TableDepthDefault,
  parameter int unsigned AddrBits   = arct_pkg::AddrBitsDefault,
  localparam int unsigned InW       = ((2 * AddrBits + arct_pkg::IndexBits + 7) / 8) * 8,
  localparam int unsigned OutBits   = arct_pkg::CountBits + 2 * AddrBits + 1,
  localparam int unsigned OutW      = ((OutBits + 7) / 8) * 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [InW-1:0]                  s_axis_tdata,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [OutW-1:0]                 m_axis_tdata,
  input logic [arct_pkg::StatusBits-1:0] m_axis_tuser
);
  import arct_pkg::*;

  // one request at a time: ready drops right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  else $error("request accepted while busy");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  else $error("stalled result changed");

  // a dropped insert only happens with a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |->
      m_axis_tdata[CountBits-1:0] == CountBits'(TableDepth))
  else $error("full status with free slots");

  // an invalid read returns no entry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_BAD_INDEX) |->
      m_axis_tdata[OutBits-1:CountBits] == '0)
  else $error("invalid read returned entry data");

endmodule

bind address_range_coalescing_table arct_checker #(
  .TableDepth (TableDepth),
  .AddrBits   (AddrBits)
) u_arct_checker (.*);
